### rtl/core/bucketed_word_lookup_unit_macros.svh
// Assertion macros for the bucketed word lookup unit.
`ifndef BUCKETED_WORD_LOOKUP_UNIT_MACROS_SVH
`define BUCKETED_WORD_LOOKUP_UNIT_MACROS_SVH

// Same-cycle implication, clocked on clk_i, off while rst_ni is low.
`define BWL_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, clocked on clk_i, off while rst_ni is low.
`define BWL_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

### rtl/core/bwl_pkg.sv
// Package: sizes, request codes, sequencer states and bucket entry type.
package bwl_pkg;

  localparam int unsigned WORD_SLOTS   = 65536;
  localparam int unsigned MAX_CHARS    = 32;
  localparam int unsigned TOO_LONG     = MAX_CHARS + 1;

  localparam int unsigned CHAR_W       = 8;
  localparam int unsigned TYPE_W       = 2;
  localparam int unsigned SLOT_FIELD_W = 17;
  localparam int unsigned LETTERS      = 256;
  localparam int unsigned LETTER_AW    = 8;

  localparam int unsigned LEN_W      = $clog2(MAX_CHARS + 2);
  localparam int unsigned CNT_W      = $clog2(WORD_SLOTS + 1);
  localparam int unsigned SCAN_W     = (CNT_W > SLOT_FIELD_W) ? CNT_W : SLOT_FIELD_W;
  localparam int unsigned SLOT_AW    = (WORD_SLOTS > 1) ? $clog2(WORD_SLOTS) : 1;
  localparam int unsigned CHAR_DEPTH = WORD_SLOTS * MAX_CHARS;
  localparam int unsigned CHAR_AW    = $clog2(CHAR_DEPTH);
  localparam int unsigned QRY_AW     = $clog2(MAX_CHARS);
  localparam int unsigned BKT_W      = 2 * SLOT_FIELD_W;

  typedef enum logic [TYPE_W-1:0] {
    REQ_LOAD   = 2'd0,
    REQ_BUCKET = 2'd1,
    REQ_QUERY  = 2'd2
  } req_type_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_BKT_RD,
    ST_BKT_CHK,
    ST_LEN_RD,
    ST_LEN_CHK,
    ST_CMP,
    ST_NEXT,
    ST_DONE
  } seq_state_e;

  typedef struct packed {
    logic [SLOT_FIELD_W-1:0] first;
    logic [SLOT_FIELD_W-1:0] stop;
  } bucket_t;

endpackage

### rtl/core/bwl_if.sv
// Interfaces: request channel and result channel.
interface bwl_req_if;
  logic                              valid;
  logic                              ready;
  logic [bwl_pkg::TYPE_W-1:0]        req_type;
  logic [bwl_pkg::CHAR_W-1:0]        char_code;
  logic                              last_char;
  logic [bwl_pkg::SLOT_FIELD_W-1:0]  bucket_start;
  logic [bwl_pkg::SLOT_FIELD_W-1:0]  bucket_stop;

  modport source (output valid, req_type, char_code, last_char, bucket_start, bucket_stop,
                  input ready);
  modport sink   (input valid, req_type, char_code, last_char, bucket_start, bucket_stop,
                  output ready);
endinterface

interface bwl_rsp_if;
  logic valid;
  logic ready;
  logic found;
  logic error_code;

  modport source (output valid, found, error_code, input ready);
  modport sink   (input valid, found, error_code, output ready);
endinterface

### rtl/core/bwl_ram.sv
// Generic single-write, single-read RAM with registered read data.
module bwl_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 256
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

### rtl/core/bucketed_word_lookup_unit.sv
// Top level: word store, bucket table, query buffer and the scan sequencer.
//
//   channel  dir  beat payload                                          handshake
//   req_i    in   req_type, char_code, last_char, bucket_start/stop     valid/ready
//   rsp_o    out  found, error_code                                     valid/ready
//
// Flow: load, bucket and non-final query beats leave the sequencer idle; a final
//   query beat starts a scan and ready stays low until IDLE. Each slot visited
//   has its length read and, on a length match, its characters compared. An
//   overlong query skips the scan; an empty or unset bucket ends it. All compares
//   share one character compare and the single read port of the word store.
// Reset: rst_ni clears word count, load position, query length, bucket valid
//   bits and the sequencer; the stores themselves hold no reset.
// Stalls: req_i.ready is high only while the sequencer idles; a finished result
//   sits in the output register and a new scan waits in DONE only if it is full.
`include "bucketed_word_lookup_unit_macros.svh"

module bucketed_word_lookup_unit (
  input  logic      clk_i,
  input  logic      rst_ni,
  bwl_req_if.sink   req_i,
  bwl_rsp_if.source rsp_o
);

  localparam int unsigned LEN_W   = bwl_pkg::LEN_W;
  localparam int unsigned CNT_W   = bwl_pkg::CNT_W;
  localparam int unsigned SCAN_W  = bwl_pkg::SCAN_W;
  localparam int unsigned SLOT_AW = bwl_pkg::SLOT_AW;
  localparam int unsigned CHAR_AW = bwl_pkg::CHAR_AW;
  localparam int unsigned QRY_AW  = bwl_pkg::QRY_AW;
  localparam int unsigned CHAR_W  = bwl_pkg::CHAR_W;

  // ---------------------------------------------------------------------------
  // Registers
  // ---------------------------------------------------------------------------
  bwl_pkg::seq_state_e         state_q, state_d;
  logic [CNT_W-1:0]            count_q;      // words loaded so far
  logic [LEN_W-1:0]            load_pos_q;   // characters of the word being loaded
  logic [CHAR_AW-1:0]          load_base_q;  // word store address of slot count_q
  logic [bwl_pkg::LETTERS-1:0] bkt_valid_q;
  logic [LEN_W-1:0]            qlen_q;       // characters of the query so far
  logic [CHAR_W-1:0]           qfirst_q;     // query first letter
  logic [LEN_W-1:0]            mlen_q;       // final query length during a scan
  logic [bwl_pkg::LETTER_AW-1:0] letter_q;
  logic [SCAN_W-1:0]           slot_q;
  logic [SCAN_W-1:0]           stop_q;
  logic [CHAR_AW-1:0]          scan_base_q;  // word store address of slot_q
  logic [LEN_W-1:0]            pos_q;        // next character index to read
  logic                        pend_q;       // a character pair is on the read ports
  logic                        res_found_q;
  logic                        res_err_q;
  logic                        out_valid_q;
  logic                        out_found_q;
  logic                        out_err_q;

  // ---------------------------------------------------------------------------
  // Request decode
  // ---------------------------------------------------------------------------
  logic acc;
  logic load_en;
  logic bkt_en;
  logic qry_en;
  logic store_full;
  logic [LEN_W-1:0] load_pos_inc;
  logic [LEN_W-1:0] qlen_inc;
  logic [CHAR_W-1:0] qletter;
  logic qry_last;
  logic qry_too_long;

  assign acc        = req_i.valid & req_i.ready;
  assign store_full = (count_q >= CNT_W'(bwl_pkg::WORD_SLOTS));
  assign load_en    = acc && (req_i.req_type == bwl_pkg::REQ_LOAD) && !store_full;
  assign bkt_en     = acc && (req_i.req_type == bwl_pkg::REQ_BUCKET);
  assign qry_en     = acc && (req_i.req_type == bwl_pkg::REQ_QUERY);

  // Both position counters saturate one past the limit to mark an overlong word.
  assign load_pos_inc = (load_pos_q < LEN_W'(bwl_pkg::TOO_LONG)) ? load_pos_q + 1'b1
                                                                  : load_pos_q;
  assign qlen_inc     = (qlen_q < LEN_W'(bwl_pkg::TOO_LONG)) ? qlen_q + 1'b1 : qlen_q;
  assign qletter      = (qlen_q == '0) ? req_i.char_code : qfirst_q;
  assign qry_last     = qry_en && req_i.last_char;
  assign qry_too_long = (qlen_inc > LEN_W'(bwl_pkg::MAX_CHARS));

  // ---------------------------------------------------------------------------
  // Memories
  // ---------------------------------------------------------------------------
  logic                 chr_we;
  logic [CHAR_AW-1:0]   chr_waddr;
  logic [CHAR_AW-1:0]   chr_raddr;
  logic [CHAR_W-1:0]    chr_rdata;
  logic                 len_we;
  logic [SLOT_AW-1:0]   len_raddr;
  logic [LEN_W-1:0]     len_rdata;
  bwl_pkg::bucket_t     bkt_wdata;
  bwl_pkg::bucket_t     bkt_rdata;
  logic                 qry_we;
  logic [QRY_AW-1:0]    qry_raddr;
  logic [CHAR_W-1:0]    qry_rdata;

  assign chr_we    = load_en && (load_pos_q < LEN_W'(bwl_pkg::MAX_CHARS));
  assign chr_waddr = load_base_q + CHAR_AW'(load_pos_q);
  assign len_we    = load_en && req_i.last_char;
  assign qry_we    = qry_en && (qlen_q < LEN_W'(bwl_pkg::MAX_CHARS));
  assign bkt_wdata = '{first: req_i.bucket_start, stop: req_i.bucket_stop};

  bwl_ram #(.WIDTH(CHAR_W), .DEPTH(bwl_pkg::CHAR_DEPTH)) u_word_chars (
    .clk_i   (clk_i),
    .we_i    (chr_we),
    .waddr_i (chr_waddr),
    .wdata_i (req_i.char_code),
    .raddr_i (chr_raddr),
    .rdata_o (chr_rdata)
  );

  bwl_ram #(.WIDTH(LEN_W), .DEPTH(bwl_pkg::WORD_SLOTS)) u_word_lengths (
    .clk_i   (clk_i),
    .we_i    (len_we),
    .waddr_i (count_q[SLOT_AW-1:0]),
    .wdata_i (load_pos_inc),
    .raddr_i (len_raddr),
    .rdata_o (len_rdata)
  );

  bwl_ram #(.WIDTH(bwl_pkg::BKT_W), .DEPTH(bwl_pkg::LETTERS)) u_buckets (
    .clk_i   (clk_i),
    .we_i    (bkt_en),
    .waddr_i (req_i.char_code),
    .wdata_i (bkt_wdata),
    .raddr_i (letter_q),
    .rdata_o (bkt_rdata)
  );

  bwl_ram #(.WIDTH(CHAR_W), .DEPTH(bwl_pkg::MAX_CHARS)) u_query_chars (
    .clk_i   (clk_i),
    .we_i    (qry_we),
    .waddr_i (qlen_q[QRY_AW-1:0]),
    .wdata_i (req_i.char_code),
    .raddr_i (qry_raddr),
    .rdata_o (qry_rdata)
  );

  // ---------------------------------------------------------------------------
  // Scan datapath terms
  // ---------------------------------------------------------------------------
  logic [SCAN_W-1:0]  bkt_first;
  logic [SCAN_W-1:0]  bkt_stop_cl;   // bucket end clamped to the word count
  logic               bkt_empty;
  logic [CHAR_AW-1:0] bkt_base;
  logic               cmp_issue;
  logic               cmp_miss;
  logic               cmp_hit;
  logic [SCAN_W-1:0]  slot_inc;
  logic               out_free;

  assign bkt_first   = SCAN_W'(bkt_rdata.first);
  assign bkt_stop_cl = (SCAN_W'(bkt_rdata.stop) > SCAN_W'(count_q)) ? SCAN_W'(count_q)
                                                                     : SCAN_W'(bkt_rdata.stop);
  assign bkt_empty   = !bkt_valid_q[letter_q] || (bkt_first >= bkt_stop_cl);
  // Only used when the bucket is not empty, so the first slot is a real slot.
  assign bkt_base    = CHAR_AW'(bkt_first[SLOT_AW-1:0]) * CHAR_AW'(bwl_pkg::MAX_CHARS);

  // One character pair compared per cycle while the next pair is read.
  assign cmp_issue = (pos_q < mlen_q);
  assign cmp_miss  = pend_q && (chr_rdata != qry_rdata);
  assign cmp_hit   = !pend_q && !cmp_issue;
  assign slot_inc  = slot_q + 1'b1;
  assign out_free  = !out_valid_q || rsp_o.ready;

  assign chr_raddr = scan_base_q + CHAR_AW'(pos_q);
  assign qry_raddr = pos_q[QRY_AW-1:0];
  assign len_raddr = slot_q[SLOT_AW-1:0];

  // ---------------------------------------------------------------------------
  // Sequencer: next state
  // ---------------------------------------------------------------------------
  always_comb begin
    state_d = state_q;
    case (state_q)
      bwl_pkg::ST_IDLE: begin
        if (qry_last) begin
          state_d = qry_too_long ? bwl_pkg::ST_DONE : bwl_pkg::ST_BKT_RD;
        end
      end
      bwl_pkg::ST_BKT_RD:  state_d = bwl_pkg::ST_BKT_CHK;
      bwl_pkg::ST_BKT_CHK: state_d = bkt_empty ? bwl_pkg::ST_DONE : bwl_pkg::ST_LEN_RD;
      bwl_pkg::ST_LEN_RD:  state_d = bwl_pkg::ST_LEN_CHK;
      bwl_pkg::ST_LEN_CHK: begin
        state_d = (len_rdata == mlen_q) ? bwl_pkg::ST_CMP : bwl_pkg::ST_NEXT;
      end
      bwl_pkg::ST_CMP: begin
        if (cmp_miss) begin
          state_d = bwl_pkg::ST_NEXT;
        end else if (cmp_hit) begin
          state_d = bwl_pkg::ST_DONE;
        end
      end
      bwl_pkg::ST_NEXT: begin
        state_d = (slot_inc >= stop_q) ? bwl_pkg::ST_DONE : bwl_pkg::ST_LEN_RD;
      end
      bwl_pkg::ST_DONE: begin
        if (out_free) begin
          state_d = bwl_pkg::ST_IDLE;
        end
      end
      default: state_d = bwl_pkg::ST_IDLE;
    endcase
  end

  // ---------------------------------------------------------------------------
  // Sequencer: outputs
  // ---------------------------------------------------------------------------
  logic out_load;

  always_comb begin
    req_i.ready = 1'b0;
    out_load    = 1'b0;
    case (state_q)
      bwl_pkg::ST_IDLE: req_i.ready = 1'b1;
      bwl_pkg::ST_DONE: out_load    = out_free;
      default: begin
        req_i.ready = 1'b0;
        out_load    = 1'b0;
      end
    endcase
  end

  assign rsp_o.valid      = out_valid_q;
  assign rsp_o.found      = out_found_q;
  assign rsp_o.error_code = out_err_q;

  // ---------------------------------------------------------------------------
  // Control registers
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= bwl_pkg::ST_IDLE;
      count_q     <= '0;
      load_pos_q  <= '0;
      load_base_q <= '0;
      bkt_valid_q <= '0;
      qlen_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= (out_valid_q && !rsp_o.ready) || out_load;
      if (load_en) begin
        if (req_i.last_char) begin
          count_q     <= count_q + 1'b1;
          load_base_q <= load_base_q + CHAR_AW'(bwl_pkg::MAX_CHARS);
          load_pos_q  <= '0;
        end else begin
          load_pos_q  <= load_pos_inc;
        end
      end
      if (bkt_en) begin
        bkt_valid_q[req_i.char_code] <= 1'b1;
      end
      if (qry_en) begin
        qlen_q <= req_i.last_char ? '0 : qlen_inc;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Scan payload registers
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk_i) begin
    if (qry_en && (qlen_q == '0)) begin
      qfirst_q <= req_i.char_code;
    end
    if (out_load) begin
      out_found_q <= res_found_q;
      out_err_q   <= res_err_q;
    end
    case (state_q)
      bwl_pkg::ST_IDLE: begin
        if (qry_last) begin
          mlen_q      <= qlen_inc;
          letter_q    <= qletter;
          res_found_q <= 1'b0;
          res_err_q   <= qry_too_long;
        end
      end
      bwl_pkg::ST_BKT_CHK: begin
        slot_q      <= bkt_first;
        stop_q      <= bkt_stop_cl;
        scan_base_q <= bkt_base;
      end
      bwl_pkg::ST_LEN_CHK: begin
        pos_q  <= '0;
        pend_q <= 1'b0;
      end
      bwl_pkg::ST_CMP: begin
        if (!cmp_miss && cmp_hit) begin
          res_found_q <= 1'b1;
        end
        pos_q  <= cmp_issue ? pos_q + 1'b1 : pos_q;
        pend_q <= cmp_issue;
      end
      bwl_pkg::ST_NEXT: begin
        slot_q      <= slot_inc;
        scan_base_q <= scan_base_q + CHAR_AW'(bwl_pkg::MAX_CHARS);
      end
      default: begin
        pend_q <= 1'b0;
      end
    endcase
  end

  // ---------------------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------------------
  `BWL_ASSERT_NOW(a_count_bound, 1'b1, count_q <= CNT_W'(bwl_pkg::WORD_SLOTS),
                  "word count beyond store size")
  `BWL_ASSERT_NOW(a_scan_in_range, state_q == bwl_pkg::ST_LEN_RD,
                  (slot_q < stop_q) && (stop_q <= SCAN_W'(count_q)),
                  "scan slot outside the clamped bucket range")
  `BWL_ASSERT_NOW(a_cmp_pos, state_q == bwl_pkg::ST_CMP,
                  (pos_q <= mlen_q) && (mlen_q <= LEN_W'(bwl_pkg::MAX_CHARS)),
                  "compare position past the query length")
  `BWL_ASSERT_NEXT(a_long_query, qry_last && qry_too_long,
                   (state_q == bwl_pkg::ST_DONE) && res_err_q && !res_found_q,
                   "overlong query not reported at once")

endmodule

### test/bucketed_word_lookup_unit_test.sv
// Testbench for the bucketed word lookup unit: directed and random traffic, self-checking.
`timescale 1ns / 1ps

module bucketed_word_lookup_unit_test;

  localparam int unsigned TYPE_W       = bwl_pkg::TYPE_W;
  localparam int unsigned CHAR_W       = bwl_pkg::CHAR_W;
  localparam int unsigned SLOT_FIELD_W = bwl_pkg::SLOT_FIELD_W;
  localparam int unsigned LEN_W        = bwl_pkg::LEN_W;
  localparam int unsigned LETTERS      = bwl_pkg::LETTERS;
  localparam int unsigned WORD_SLOTS   = bwl_pkg::WORD_SLOTS;
  localparam int unsigned MAX_CHARS    = bwl_pkg::MAX_CHARS;
  localparam int unsigned TOO_LONG     = bwl_pkg::TOO_LONG;

  localparam bwl_pkg::req_type_e REQ_LOAD   = bwl_pkg::REQ_LOAD;
  localparam bwl_pkg::req_type_e REQ_BUCKET = bwl_pkg::REQ_BUCKET;
  localparam bwl_pkg::req_type_e REQ_QUERY  = bwl_pkg::REQ_QUERY;

  // Request code the block does not know; it must swallow the beat silently.
  localparam logic [TYPE_W-1:0] REQ_RESERVED = 2'd3;

  // A scan visits at most the slots loaded here: each slot has its length read and
  // checked and, on a length match, its characters compared one pair at a time. The
  // CYCLE_LIMIT timeout sits far above what the run needs even if every query scanned that far.
  localparam int unsigned CYCLE_LIMIT = 10_000_000;
  localparam int unsigned DRAIN_CYCLES = 64;
  localparam logic [SLOT_FIELD_W-1:0] SLOT_ALL_ONES = '1;

  typedef bit [CHAR_W-1:0] text_q_t[$];

  typedef struct {
    bit found;
    bit overlong;
  } verdict_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;

  bwl_req_if req_ch ();
  bwl_rsp_if rsp_ch ();

  bucketed_word_lookup_unit dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (req_ch),
    .rsp_o  (rsp_ch)
  );

  // 12 ns period.
  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  // ---------------------------------------------------------------------
  // Shadow of the block's state, updated on every accepted request beat.
  // ---------------------------------------------------------------------
  bit [CHAR_W-1:0]       lex_chars [WORD_SLOTS][MAX_CHARS];
  bit [LEN_W-1:0]        lex_len   [WORD_SLOTS];
  int unsigned           lex_count;
  int unsigned           load_pos;
  bit [SLOT_FIELD_W-1:0] bkt_first [LETTERS];
  bit [SLOT_FIELD_W-1:0] bkt_stop  [LETTERS];
  bit                    bkt_set   [LETTERS];
  bit [CHAR_W-1:0]       qry_chars [MAX_CHARS];
  int unsigned           qry_len;

  // Lookup verdicts owed by the block, oldest first.
  verdict_t pending_verdicts[$];

  int unsigned send_idle_pct;
  int unsigned recv_idle_pct;
  int unsigned beats_sent;
  int unsigned lookups_checked;
  int unsigned hit_count;
  int unsigned overlong_count;
  int unsigned mismatch_count;
  int unsigned cycle_count;

  // Long receiver hold-off: bump hold_req with hold_len set; the response
  // side counts the stretch down on its own.
  int unsigned hold_req;
  int unsigned hold_len;

  // Linear scan of the query's bucket, end clamped to the loaded word count.
  function automatic bit bucket_holds_query();
    int unsigned letter;
    int unsigned stop;
    int unsigned s;
    int unsigned i;
    bit same;
    letter = qry_chars[0];
    if (!bkt_set[letter]) return 1'b0;
    stop = bkt_stop[letter];
    if (stop > lex_count) stop = lex_count;
    for (s = bkt_first[letter]; s < stop; s++) begin
      if (lex_len[s] == qry_len) begin
        same = 1'b1;
        for (i = 0; i < qry_len; i++)
          if (lex_chars[s][i] != qry_chars[i]) same = 1'b0;
        if (same) return 1'b1;
      end
    end
    return 1'b0;
  endfunction

  // Advance the shadow by one accepted beat; a query end owes one verdict.
  function automatic void apply_request(logic [TYPE_W-1:0] kind, logic [CHAR_W-1:0] ch,
                                        logic last, logic [SLOT_FIELD_W-1:0] first,
                                        logic [SLOT_FIELD_W-1:0] stop);
    verdict_t v;
    case (kind)
      REQ_LOAD: begin
        // full store drops load beats entirely
        if (lex_count < WORD_SLOTS) begin
          if (load_pos < MAX_CHARS) lex_chars[lex_count][load_pos] = ch;
          if (load_pos < TOO_LONG) load_pos++;
          if (last) begin
            lex_len[lex_count] = LEN_W'(load_pos);
            lex_count++;
            load_pos = 0;
          end
        end
      end
      REQ_BUCKET: begin
        bkt_first[ch] = first;
        bkt_stop[ch]  = stop;
        bkt_set[ch]   = 1'b1;
      end
      REQ_QUERY: begin
        if (qry_len < MAX_CHARS) qry_chars[qry_len] = ch;
        if (qry_len < TOO_LONG) qry_len++;
        if (last) begin
          v.overlong = (qry_len > MAX_CHARS);
          v.found    = v.overlong ? 1'b0 : bucket_holds_query();
          pending_verdicts.push_back(v);
          qry_len = 0;
        end
      end
      default: ;
    endcase
  endfunction

  // ---------------------------------------------------------------------
  // Request side: one beat per call, random idle cycles ahead of it.
  // Inputs change on the falling edge, acceptance is seen on the rising.
  // ---------------------------------------------------------------------
  task automatic send_beat(logic [TYPE_W-1:0] kind, logic [CHAR_W-1:0] ch, logic last,
                           logic [SLOT_FIELD_W-1:0] first = '0,
                           logic [SLOT_FIELD_W-1:0] stop = '0);
    @(negedge clk_i);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      req_ch.valid <= 1'b0;
      @(negedge clk_i);
    end
    req_ch.valid        <= 1'b1;
    req_ch.req_type     <= kind;
    req_ch.char_code    <= ch;
    req_ch.last_char    <= last;
    req_ch.bucket_start <= first;
    req_ch.bucket_stop  <= stop;
    do @(posedge clk_i); while (!req_ch.ready);
    apply_request(kind, ch, last, first, stop);
    if (kind != REQ_RESERVED) beats_sent++;
  endtask

  task automatic send_word(logic [TYPE_W-1:0] kind, text_q_t text);
    int unsigned i;
    for (i = 0; i < text.size(); i++)
      send_beat(kind, text[i], i == text.size() - 1);
  endtask

  task automatic set_bucket(logic [CHAR_W-1:0] letter, logic [SLOT_FIELD_W-1:0] first,
                            logic [SLOT_FIELD_W-1:0] stop);
    send_beat(REQ_BUCKET, letter, 1'b0, first, stop);
  endtask

  // ---------------------------------------------------------------------
  // Response side: ready with random gaps, or held low for a long stretch.
  // ---------------------------------------------------------------------
  initial begin : rsp_ready_driver
    int unsigned hold_seen;
    int unsigned hold_left;
    hold_seen = 0;
    hold_left = 0;
    rsp_ch.ready = 1'b0;
    forever begin
      @(negedge clk_i);
      if (hold_seen != hold_req) begin
        hold_seen = hold_req;
        hold_left = hold_len;
      end
      if (hold_left > 0) begin
        hold_left--;
        rsp_ch.ready <= 1'b0;
      end else begin
        rsp_ch.ready <= ($urandom_range(0, 99) >= recv_idle_pct);
      end
    end
  end

  // Every accepted result against the oldest owed verdict.
  always @(posedge clk_i) begin : verdict_checker
    verdict_t want;
    if (rst_ni && rsp_ch.valid && rsp_ch.ready) begin
      if (pending_verdicts.size() == 0) begin
        $display("%0t: unexpected result found=%0b error_code=%0b", $time,
                 rsp_ch.found, rsp_ch.error_code);
        mismatch_count++;
      end else begin
        want = pending_verdicts.pop_front();
        lookups_checked++;
        if (want.found) hit_count++;
        if (want.overlong) overlong_count++;
        if (rsp_ch.found !== want.found) begin
          $display("%0t: found mismatch, expected %0b actual %0b", $time,
                   want.found, rsp_ch.found);
          mismatch_count++;
        end
        if (rsp_ch.error_code !== want.overlong) begin
          $display("%0t: error_code mismatch, expected %0b actual %0b", $time,
                   want.overlong, rsp_ch.error_code);
          mismatch_count++;
        end
      end
    end
  end

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("%0t: timeout with %0d results outstanding", $time, pending_verdicts.size());
      $display("bucketed_word_lookup_unit test failed");
      $finish;
    end
  end

  // ---------------------------------------------------------------------
  // Stimulus helpers
  // ---------------------------------------------------------------------

  // A handful of first letters so buckets collide; the extremes included.
  function automatic bit [CHAR_W-1:0] pick_letter();
    bit [CHAR_W-1:0] pool[8];
    pool = '{8'h00, 8'hFF, 8'h61, 8'h62, 8'h63, 8'h5A, 8'h80, 8'h3F};
    if ($urandom_range(0, 99) < 85) return pool[$urandom_range(0, 7)];
    return CHAR_W'($urandom_range(0, 255));
  endfunction

  function automatic text_q_t random_text();
    text_q_t t;
    int unsigned n;
    int unsigned roll;
    roll = $urandom_range(0, 99);
    if (roll < 85) n = $urandom_range(1, 6);
    else if (roll < 95) n = $urandom_range(7, MAX_CHARS);
    else n = $urandom_range(MAX_CHARS + 1, MAX_CHARS + 8);
    t.push_back(pick_letter());
    while (t.size() < n) t.push_back(CHAR_W'($urandom_range(0, 255)));
    return t;
  endfunction

  // Stored text of a slot; an overlong word gives its first MAX_CHARS only.
  function automatic text_q_t stored_text(int unsigned slot);
    text_q_t t;
    int unsigned n;
    int unsigned i;
    n = (lex_len[slot] > MAX_CHARS) ? MAX_CHARS : lex_len[slot];
    for (i = 0; i < n; i++) t.push_back(lex_chars[slot][i]);
    return t;
  endfunction

  task automatic set_random_bucket();
    int unsigned roll;
    int unsigned first;
    int unsigned stop;
    roll = $urandom_range(0, 99);
    if (roll < 40) begin
      // wide: most of the loaded store
      first = $urandom_range(0, lex_count / 4);
      stop  = lex_count + $urandom_range(0, 3);
    end else if (roll < 70) begin
      first = $urandom_range(0, lex_count);
      stop  = first + $urandom_range(0, 40);
    end else if (roll < 80) begin
      first = $urandom_range(0, lex_count / 2);
      stop  = roll[0] ? SLOT_ALL_ONES : WORD_SLOTS;
    end else if (roll < 90) begin
      // empty range, start past stop
      stop  = $urandom_range(0, lex_count);
      first = stop + $urandom_range(1, 20);
    end else begin
      first = $urandom_range(0, SLOT_ALL_ONES);
      stop  = $urandom_range(0, SLOT_ALL_ONES);
    end
    set_bucket(pick_letter(), SLOT_FIELD_W'(first), SLOT_FIELD_W'(stop));
  endtask

  // Mostly stored words, some near misses, some fresh words; now and then a
  // reserved beat lands just ahead of the query's last beat.
  task automatic query_random_word();
    text_q_t t;
    int unsigned roll;
    int unsigned i;
    roll = $urandom_range(0, 99);
    if (roll < 65) begin
      t = stored_text($urandom_range(0, lex_count - 1));
    end else if (roll < 80) begin
      t = stored_text($urandom_range(0, lex_count - 1));
      case ($urandom_range(0, 2))
        0: begin
          i = $urandom_range(0, t.size() - 1);
          t[i] = t[i] ^ CHAR_W'($urandom_range(1, 255));
        end
        1: if (t.size() > 1) void'(t.pop_back());
        default: t.push_back(CHAR_W'($urandom_range(0, 255)));
      endcase
    end else begin
      t = random_text();
    end
    for (i = 0; i < t.size(); i++) begin
      if (i == t.size() - 1 && $urandom_range(0, 99) < 5)
        send_beat(REQ_RESERVED, CHAR_W'($urandom_range(0, 255)), 1'b1);
      send_beat(REQ_QUERY, t[i], i == t.size() - 1);
    end
  endtask

  // ---------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------

  // Queries into buckets that were never written.
  task automatic test_unset_bucket();
    send_word(REQ_QUERY, '{8'h61});
    send_word(REQ_QUERY, '{8'h00, 8'hFF});
  endtask

  // Length extremes, clamped and empty ranges, overlong words and queries.
  task automatic test_directed_cases();
    text_q_t full_word;
    text_q_t long_word;
    int unsigned i;
    full_word.push_back(8'h61);
    for (i = 1; i < MAX_CHARS; i++) full_word.push_back(CHAR_W'(8'h20 + i));
    long_word = full_word;
    long_word[1] = 8'h7F;
    long_word.push_back(8'h55);
    long_word.push_back(8'hAA);

    send_word(REQ_LOAD, '{8'h61});              // slot 0
    send_word(REQ_LOAD, '{8'h61, 8'h62});       // slot 1
    send_word(REQ_LOAD, '{8'hFF, 8'h00});       // slot 2
    send_word(REQ_LOAD, full_word);             // slot 3, exactly MAX_CHARS
    send_word(REQ_LOAD, long_word);             // slot 4, marked overlong

    // stop past the loaded count gets clamped
    set_bucket(8'h61, '0, SLOT_ALL_ONES);
    send_word(REQ_QUERY, '{8'h61});
    send_word(REQ_QUERY, '{8'h61, 8'h62});
    send_word(REQ_QUERY, '{8'h61, 8'h63});
    send_word(REQ_QUERY, full_word);
    long_word = long_word[0:MAX_CHARS-1];       // prefix of the overlong word
    send_word(REQ_QUERY, long_word);
    full_word.push_back(8'h41);                 // query one past MAX_CHARS
    send_word(REQ_QUERY, full_word);

    set_bucket(8'hFF, SLOT_ALL_ONES, '0);
    send_word(REQ_QUERY, '{8'hFF, 8'h00});
    set_bucket(8'hFF, 17'd2, 17'd3);
    send_word(REQ_QUERY, '{8'hFF, 8'h00});
    set_bucket(8'hFF, 17'd3, 17'(WORD_SLOTS));
    send_word(REQ_QUERY, '{8'hFF, 8'h00});

    send_beat(REQ_RESERVED, 8'hFF, 1'b1, SLOT_ALL_ONES, SLOT_ALL_ONES);
  endtask

  // Results back up while the response side is held off; requests stall.
  task automatic test_backpressure();
    int unsigned i;
    send_idle_pct = 0;
    recv_idle_pct = 0;
    set_bucket(8'h61, '0, SLOT_ALL_ONES);
    hold_len = 400;
    hold_req++;
    for (i = 0; i < 10; i++)
      send_word(REQ_QUERY, stored_text($urandom_range(0, lex_count - 1)));
  endtask

  task automatic run_random_traffic(int unsigned beat_goal, int unsigned tx_idle,
                                    int unsigned rx_idle);
    int unsigned start;
    int unsigned roll;
    send_idle_pct = tx_idle;
    recv_idle_pct = rx_idle;
    start = beats_sent;
    while (beats_sent - start < beat_goal) begin
      roll = $urandom_range(0, 99);
      if (roll < 30) send_word(REQ_LOAD, random_text());
      else if (roll < 42) set_random_bucket();
      else if (roll < 45) send_beat(REQ_RESERVED, CHAR_W'($urandom_range(0, 255)),
                                    1'($urandom_range(0, 1)));
      else query_random_word();
    end
  endtask

  initial begin
    req_ch.valid        = 1'b0;
    req_ch.req_type     = REQ_LOAD;
    req_ch.char_code    = '0;
    req_ch.last_char    = 1'b0;
    req_ch.bucket_start = '0;
    req_ch.bucket_stop  = '0;
    send_idle_pct = 0;
    recv_idle_pct = 0;
    hold_req = 0;
    hold_len = 0;
    lex_count = 0;
    load_pos = 0;
    qry_len = 0;
    foreach (bkt_set[i]) bkt_set[i] = 1'b0;

    repeat (5) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    test_unset_bucket();
    test_directed_cases();
    test_backpressure();
    run_random_traffic(600, 34, 60);
    run_random_traffic(600, 60, 34);
    run_random_traffic(600, 0, 0);

    @(negedge clk_i);
    req_ch.valid <= 1'b0;
    while (pending_verdicts.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    $display("Sent %0d request beats, store holds %0d words.", beats_sent, lex_count);
    $display("Checked %0d lookups: %0d hits, %0d overlong queries, %0d mismatches.",
             lookups_checked, hit_count, overlong_count, mismatch_count);
    if (mismatch_count == 0) begin
      $display("bucketed_word_lookup_unit test passed");
    end else begin
      $display("bucketed_word_lookup_unit test failed");
    end
    $finish;
  end

endmodule
